@@ hw/rtl/sr_arq_pkg.sv @@
package sr_arq_pkg;

  localparam int unsigned WindowDef = 16;
  localparam int unsigned SeqCountDef = 32;
  localparam int unsigned PayloadBitsDef = 64;
  localparam int unsigned SeqW = 5;

  localparam logic [2:0] OpPacket = 3'd0;
  localparam logic [2:0] OpPhysReady = 3'd1;
  localparam logic [2:0] OpFrame = 3'd2;
  localparam logic [2:0] OpDataTimeout = 3'd3;
  localparam logic [2:0] OpAckTimeout = 3'd4;

  localparam logic [1:0] KindData = 2'd0;
  localparam logic [1:0] KindAck = 2'd1;
  localparam logic [1:0] KindNak = 2'd2;

  localparam logic [1:0] ActSend = 2'd0;
  localparam logic [1:0] ActDeliver = 2'd1;
  localparam logic [1:0] ActStopTimer = 2'd2;
  localparam logic [1:0] ActStatus = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;      // latch the input transaction
    logic emit_status;  // load the status result
    logic send_new;     // store and send a new packet
    logic set_phys;     // physical layer ready
    logic send_nak;     // send a NAK for recv_lower
    logic resend;       // resend the frame chosen by sel_nak
    logic sel_nak;      // resend ack+1 instead of the timeout sequence
    logic ack_frame;    // send a standalone ACK
    logic ack_step;     // retire one acknowledged frame
    logic store_rx;     // store a received data frame
    logic deliver;      // deliver recv_lower
  } sr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic win_full;
    logic nak_ok;
    logic nak_in_win;
    logic ack_more;
    logic rx_accept;
    logic rx_is_lower;
    logic deliver_more;
    logic good;
    logic [1:0] kind;
    logic [2:0] op;
  } sr_stat_t;

  function automatic logic in_window(input logic [SeqW-1:0] lo, input logic [SeqW-1:0] x,
                                     input logic [SeqW-1:0] hi);
    return (lo <= x && x < hi) || (hi < lo && x >= lo) || (x < hi && hi < lo);
  endfunction

endpackage

@@ hw/rtl/sr_arq_if.sv @@
interface sr_arq_in_if #(parameter int unsigned PayloadBits = 64);
  logic valid;
  logic ready;
  logic [2:0] op;
  logic [PayloadBits-1:0] packet_word;
  logic frame_good;
  logic [1:0] frame_kind;
  logic [4:0] frame_seq;
  logic [4:0] rx_ack;
  logic [4:0] timeout_seq;
  modport source (output valid, op, packet_word, frame_good, frame_kind, frame_seq,
                  rx_ack, timeout_seq, input ready);
  modport sink (input valid, op, packet_word, frame_good, frame_kind, frame_seq,
                rx_ack, timeout_seq, output ready);
endinterface

interface sr_arq_out_if #(parameter int unsigned PayloadBits = 64);
  logic valid;
  logic ready;
  logic [1:0] action;
  logic [1:0] out_kind;
  logic [4:0] out_seq;
  logic [4:0] out_ack;
  logic [PayloadBits-1:0] payload;
  logic [4:0] timer_seq;
  logic network_enable;
  logic last;
  modport source (output valid, action, out_kind, out_seq, out_ack, payload, timer_seq,
                  network_enable, last, input ready);
  modport sink (input valid, action, out_kind, out_seq, out_ack, payload, timer_seq,
                network_enable, last, output ready);
endinterface

@@ hw/rtl/sr_arq_datapath.sv @@
module sr_arq_datapath #(
  parameter int unsigned PayloadBits = sr_arq_pkg::PayloadBitsDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  sr_arq_pkg::sr_cmd_t cmd_i,
  output sr_arq_pkg::sr_stat_t stat_o,
  sr_arq_in_if.sink in_i,
  output logic [1:0] action_o,
  output logic [1:0] out_kind_o,
  output logic [4:0] out_seq_o,
  output logic [4:0] out_ack_o,
  output logic [PayloadBits-1:0] payload_o,
  output logic [4:0] timer_seq_o,
  output logic network_enable_o,
  output logic last_o
);
  import sr_arq_pkg::*;

  localparam int unsigned Window = WindowDef;
  localparam int unsigned SeqCount = SeqCountDef;
  localparam int unsigned IdxW = (Window > 1) ? $clog2(Window) : 1;
  localparam int unsigned CntW = $clog2(Window + 1);
  localparam logic [SeqW-1:0] SeqMax = SeqW'(SeqCount - 1);

  function automatic logic [SeqW-1:0] inc(input logic [SeqW-1:0] v);
    return (v == SeqMax) ? '0 : v + 1'b1;
  endfunction
  function automatic logic [SeqW-1:0] md(input logic [SeqW-1:0] v);
    return (v >= SeqW'(SeqCount)) ? v - SeqW'(SeqCount) : v;
  endfunction
  function automatic logic [IdxW-1:0] slot(input logic [SeqW-1:0] v);
    return IdxW'(v % Window);
  endfunction

  logic [SeqW-1:0] send_lower_q, send_next_q, recv_lower_q, recv_upper_q;
  logic [CntW-1:0] outst_q;
  logic nak_allowed_q, phys_q;
  logic [Window-1:0] arrived_q;
  logic [PayloadBits-1:0] send_store [Window];
  logic [PayloadBits-1:0] recv_store [Window];

  logic [2:0] op_q;
  logic [PayloadBits-1:0] word_q;
  logic good_q;
  logic [1:0] kind_q;
  logic [SeqW-1:0] seq_q, ack_q, tseq_q;

  logic [SeqW-1:0] prev_ack, nak_seq, rs_seq;
  assign prev_ack = (recv_lower_q == '0) ? SeqMax : recv_lower_q - 1'b1;
  assign nak_seq = inc(ack_q);
  assign rs_seq = cmd_i.sel_nak ? nak_seq : tseq_q;

  assign stat_o.win_full = (outst_q >= CntW'(Window));
  assign stat_o.nak_ok = nak_allowed_q;
  assign stat_o.nak_in_win = in_window(send_lower_q, nak_seq, send_next_q);
  assign stat_o.ack_more = in_window(send_lower_q, ack_q, send_next_q) && (outst_q != '0);
  assign stat_o.rx_accept = in_window(recv_lower_q, seq_q, recv_upper_q)
                            && !arrived_q[slot(seq_q)];
  assign stat_o.rx_is_lower = (seq_q == recv_lower_q);
  assign stat_o.deliver_more = arrived_q[slot(recv_lower_q)];
  assign stat_o.good = good_q;
  assign stat_o.kind = kind_q;
  assign stat_o.op = op_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q <= in_i.op;
      word_q <= in_i.packet_word;
      good_q <= in_i.frame_good;
      kind_q <= in_i.frame_kind;
      seq_q <= md(in_i.frame_seq);
      ack_q <= md(in_i.rx_ack);
      tseq_q <= md(in_i.timeout_seq);
    end
    if (cmd_i.send_new) send_store[slot(send_next_q)] <= word_q;
    if (cmd_i.store_rx) recv_store[slot(seq_q)] <= word_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      send_lower_q <= '0;
      send_next_q <= '0;
      outst_q <= '0;
      recv_lower_q <= '0;
      recv_upper_q <= SeqW'(Window % SeqCount);
      arrived_q <= '0;
      nak_allowed_q <= 1'b1;
      phys_q <= 1'b0;
    end else begin
      if (cmd_i.set_phys) phys_q <= 1'b1;
      if (cmd_i.send_new || cmd_i.resend || cmd_i.send_nak || cmd_i.ack_frame) phys_q <= 1'b0;
      if (cmd_i.send_nak) nak_allowed_q <= 1'b0;
      if (cmd_i.send_new) begin
        send_next_q <= inc(send_next_q);
        outst_q <= outst_q + 1'b1;
      end
      if (cmd_i.ack_step) begin
        send_lower_q <= inc(send_lower_q);
        outst_q <= outst_q - 1'b1;
      end
      if (cmd_i.store_rx) arrived_q[slot(seq_q)] <= 1'b1;
      if (cmd_i.deliver) begin
        arrived_q[slot(recv_lower_q)] <= 1'b0;
        recv_lower_q <= inc(recv_lower_q);
        recv_upper_q <= inc(recv_upper_q);
        nak_allowed_q <= 1'b1;
      end
    end
  end

  // Result register; the controller loads it only when the output is free.
  always_ff @(posedge clk_i) begin
    if (cmd_i.send_new || cmd_i.resend || cmd_i.send_nak || cmd_i.ack_frame
        || cmd_i.ack_step || cmd_i.deliver || cmd_i.emit_status) begin
      action_o <= ActSend;
      out_kind_o <= KindData;
      out_seq_o <= '0;
      out_ack_o <= '0;
      payload_o <= '0;
      timer_seq_o <= '0;
      network_enable_o <= 1'b0;
      last_o <= 1'b0;
      if (cmd_i.send_new) begin
        out_seq_o <= send_next_q;
        out_ack_o <= prev_ack;
        payload_o <= word_q;
      end else if (cmd_i.resend) begin
        out_seq_o <= rs_seq;
        out_ack_o <= prev_ack;
        payload_o <= send_store[slot(rs_seq)];
      end else if (cmd_i.send_nak) begin
        out_kind_o <= KindNak;
        out_ack_o <= prev_ack;
      end else if (cmd_i.ack_frame) begin
        out_kind_o <= KindAck;
        out_ack_o <= prev_ack;
      end else if (cmd_i.ack_step) begin
        action_o <= ActStopTimer;
        timer_seq_o <= send_lower_q;
      end else if (cmd_i.deliver) begin
        action_o <= ActDeliver;
        payload_o <= recv_store[slot(recv_lower_q)];
      end else begin
        action_o <= ActStatus;
        network_enable_o <= (outst_q < CntW'(Window)) && phys_q;
        last_o <= 1'b1;
      end
    end
  end
endmodule

@@ hw/rtl/sr_arq_ctrl.sv @@
module sr_arq_ctrl (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  sr_arq_pkg::sr_stat_t stat_i,
  output sr_arq_pkg::sr_cmd_t cmd_o
);
  import sr_arq_pkg::*;

  typedef enum logic [6:0] {
    StIdle    = 7'b0000001,
    StDecode  = 7'b0000010,
    StRxNak   = 7'b0000100,
    StRxStore = 7'b0001000,
    StDeliver = 7'b0010000,
    StAck     = 7'b0100000,
    StStatus  = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic free;

  assign free = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign in_ready_o = (state_q == StIdle);

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = StDecode;
        end
      end
      StDecode: begin
        if (free) begin
          state_d = StStatus;
          case (stat_i.op)
            OpPacket: if (!stat_i.win_full) begin
              cmd_o.send_new = 1'b1;
              out_valid_d = 1'b1;
            end
            OpPhysReady: cmd_o.set_phys = 1'b1;
            OpFrame: begin
              if (!stat_i.good) begin
                if (stat_i.nak_ok) begin
                  cmd_o.send_nak = 1'b1;
                  out_valid_d = 1'b1;
                end
              end else if (stat_i.kind == KindAck) begin
                state_d = StAck;
              end else if (stat_i.kind == KindNak) begin
                if (stat_i.nak_in_win) begin
                  cmd_o.resend = 1'b1;
                  cmd_o.sel_nak = 1'b1;
                  out_valid_d = 1'b1;
                end
                state_d = StAck;
              end else if (stat_i.kind == KindData) begin
                state_d = stat_i.rx_accept ? StRxNak : StAck;
              end
            end
            OpDataTimeout: begin
              cmd_o.resend = 1'b1;
              out_valid_d = 1'b1;
            end
            OpAckTimeout: begin
              cmd_o.ack_frame = 1'b1;
              out_valid_d = 1'b1;
            end
            default: ;
          endcase
        end
      end
      StRxNak: begin
        if (free) begin
          if (!stat_i.rx_is_lower && stat_i.nak_ok) begin
            cmd_o.send_nak = 1'b1;
            out_valid_d = 1'b1;
          end
          state_d = StRxStore;
        end
      end
      StRxStore: begin
        cmd_o.store_rx = 1'b1;
        state_d = StDeliver;
      end
      StDeliver: begin
        if (!stat_i.deliver_more) begin
          state_d = StAck;
        end else if (free) begin
          cmd_o.deliver = 1'b1;
          out_valid_d = 1'b1;
        end
      end
      StAck: begin
        if (!stat_i.ack_more) begin
          state_d = StStatus;
        end else if (free) begin
          cmd_o.ack_step = 1'b1;
          out_valid_d = 1'b1;
        end
      end
      StStatus: begin
        if (free) begin
          cmd_o.emit_status = 1'b1;
          out_valid_d = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      out_valid_q <= out_valid_d;
    end
  end
endmodule

@@ hw/rtl/selective_repeat_arq.sv @@
// Selective-repeat sliding-window ARQ endpoint.
// in_i carries one event per transaction (op selects packet, physical ready,
// received frame, data timeout or ack timeout). out_o returns the actions
// that event causes: frames to send, packets delivered in order and data
// timers to stop, followed by one status transaction with last set and the
// network enable flag.
// One event is handled at a time: in_i is ready only when the controller
// is idle. Each event passes the decode and status steps. A received ack
// or NAK frame, or a data frame outside the receive window, also passes
// the ack step, which retires acknowledged frames one by one; an accepted
// data frame also passes the NAK check, the store, the delivery step and
// the ack step, with up to one window of deliveries and of retired frames.
// Each result sits in an output register; when the receiver stalls, the
// controller holds before the next result until that register is taken.
// Reset clears the windows, arrived marks and phys-ready flag and sets
// the NAK-allowed flag; payload stores hold anything until written.
module selective_repeat_arq #(
  parameter int unsigned PayloadBits = sr_arq_pkg::PayloadBitsDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  sr_arq_in_if.sink in_i,
  sr_arq_out_if.source out_o
);
  import sr_arq_pkg::*;

  sr_cmd_t cmd;
  sr_stat_t stat;
  logic rdy;

  assign in_i.ready = rdy;

  sr_arq_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(in_i.valid), .in_ready_o(rdy),
    .out_valid_o(out_o.valid), .out_ready_i(out_o.ready),
    .stat_i(stat), .cmd_o(cmd)
  );

  sr_arq_datapath #(.PayloadBits(PayloadBits)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .stat_o(stat), .in_i(in_i),
    .action_o(out_o.action), .out_kind_o(out_o.out_kind), .out_seq_o(out_o.out_seq),
    .out_ack_o(out_o.out_ack), .payload_o(out_o.payload), .timer_seq_o(out_o.timer_seq),
    .network_enable_o(out_o.network_enable), .last_o(out_o.last)
  );
endmodule

@@ hw/rtl/sr_arq_checker.sv @@
module sr_arq_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic [1:0] action_i,
  input logic last_i
);
  import sr_arq_pkg::*;

  a_last_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (last_i == (action_i == ActStatus))) else $error("last mismatch");
  a_no_ready_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i) else $error("ready after accept");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> out_valid_i && $stable(action_i))
    else $error("stall lost");
endmodule

bind selective_repeat_arq sr_arq_checker u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(in_i.valid), .in_ready_i(in_i.ready),
  .out_valid_i(out_o.valid), .out_ready_i(out_o.ready), .action_i(out_o.action),
  .last_i(out_o.last)
);

@@ verif/selective_repeat_arq_tb.sv @@
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import sr_arq_pkg::*;

  localparam int unsigned Win = 16;
  localparam int unsigned IdleLimit = 20000;

  typedef struct packed {
    logic [1:0] action;
    logic [1:0] out_kind;
    logic [4:0] out_seq;
    logic [4:0] out_ack;
    logic [63:0] payload;
    logic [4:0] timer_seq;
    logic network_enable;
    logic last;
  } arq_result_t;

  typedef struct packed {
    logic [2:0] op;
    logic [63:0] packet_word;
    logic frame_good;
    logic [1:0] frame_kind;
    logic [4:0] frame_seq;
    logic [4:0] rx_ack;
    logic [4:0] timeout_seq;
  } arq_event_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int unsigned errors = 0;
  bit out_idle_on = 1'b1;

  sr_arq_in_if #(.PayloadBits(64)) ev_if ();
  sr_arq_out_if #(.PayloadBits(64)) act_if ();

  selective_repeat_arq dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_i(ev_if.sink),
    .out_o(act_if.source)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  task automatic report(input string what);
    $display("mismatch: %s", what);
    errors++;
  endtask

  class arq_scoreboard;
    logic [4:0] snd_lo, snd_nx, snd_out, rcv_lo, rcv_hi;
    logic [63:0] snd_buf[Win];
    logic [63:0] rcv_buf[Win];
    bit got[Win];
    bit nak_ok, phys;
    arq_result_t pending[$];

    function void clear();
      snd_lo = '0; snd_nx = '0; snd_out = '0; rcv_lo = '0; rcv_hi = 5'(Win);
      foreach (got[i]) got[i] = 1'b0;
      nak_ok = 1'b1; phys = 1'b0;
      pending.delete();
    endfunction

    function bit within_win(logic [4:0] lo, logic [4:0] x, logic [4:0] hi);
      return (lo <= x && x < hi) || (hi < lo && x >= lo) || (x < hi && hi < lo);
    endfunction

    function void push(logic [1:0] act, logic [1:0] kind, logic [4:0] sq, logic [4:0] ak,
                       logic [63:0] pay, logic [4:0] ts, bit ne, bit lst);
      arq_result_t r;
      r = '{act, kind, sq, ak, pay, ts, ne, lst};
      pending.push_back(r);
    endfunction

    function void queue_data(logic [4:0] sq);
      phys = 1'b0;
      push(ActSend, KindData, sq, rcv_lo - 5'd1, snd_buf[sq % Win], 0, 0, 0);
    endfunction

    function void send_nak();
      nak_ok = 1'b0; phys = 1'b0;
      push(ActSend, KindNak, 0, rcv_lo - 5'd1, 0, 0, 0, 0);
    endfunction

    function void retire(logic [4:0] ak);
      while (within_win(snd_lo, ak, snd_nx) && snd_out > 0) begin
        push(ActStopTimer, 0, 0, 0, 0, snd_lo, 0, 0);
        snd_lo++;
        snd_out--;
      end
    endfunction

    function void note_event(arq_event_t e);
      case (e.op)
        OpPacket: begin
          if (snd_out < Win) begin
            snd_buf[snd_nx % Win] = e.packet_word;
            snd_out++;
            queue_data(snd_nx);
            snd_nx++;
          end
        end
        OpPhysReady: phys = 1'b1;
        OpFrame: begin
          if (!e.frame_good) begin
            if (nak_ok) send_nak();
          end else if (e.frame_kind == KindAck) begin
            retire(e.rx_ack);
          end else if (e.frame_kind == KindNak) begin
            if (within_win(snd_lo, e.rx_ack + 5'd1, snd_nx)) queue_data(e.rx_ack + 5'd1);
            retire(e.rx_ack);
          end else if (e.frame_kind == KindData) begin
            if (within_win(rcv_lo, e.frame_seq, rcv_hi) && !got[e.frame_seq % Win]) begin
              if (e.frame_seq != rcv_lo && nak_ok) send_nak();
              got[e.frame_seq % Win] = 1'b1;
              rcv_buf[e.frame_seq % Win] = e.packet_word;
              while (got[rcv_lo % Win]) begin
                push(ActDeliver, 0, 0, 0, rcv_buf[rcv_lo % Win], 0, 0, 0);
                got[rcv_lo % Win] = 1'b0;
                rcv_lo++;
                rcv_hi++;
                nak_ok = 1'b1;
              end
            end
            retire(e.rx_ack);
          end
        end
        OpDataTimeout: queue_data(e.timeout_seq);
        OpAckTimeout: begin
          phys = 1'b0;
          push(ActSend, KindAck, 0, rcv_lo - 5'd1, 0, 0, 0, 0);
        end
        default: ;
      endcase
      push(ActStatus, 0, 0, 0, 0, 0, snd_out < Win && phys, 1'b1);
    endfunction

    task check_result(arq_result_t got_r);
      arq_result_t exp_r;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result %p", got_r));
        return;
      end
      exp_r = pending.pop_front();
      if (got_r.action !== exp_r.action)
        report($sformatf("action %0d exp %0d", got_r.action, exp_r.action));
      if (got_r.out_kind !== exp_r.out_kind)
        report($sformatf("out_kind %0d exp %0d", got_r.out_kind, exp_r.out_kind));
      if (got_r.out_seq !== exp_r.out_seq)
        report($sformatf("out_seq %0d exp %0d", got_r.out_seq, exp_r.out_seq));
      if (got_r.out_ack !== exp_r.out_ack)
        report($sformatf("out_ack %0d exp %0d", got_r.out_ack, exp_r.out_ack));
      if (got_r.payload !== exp_r.payload)
        report($sformatf("payload %h exp %h", got_r.payload, exp_r.payload));
      if (got_r.timer_seq !== exp_r.timer_seq)
        report($sformatf("timer_seq %0d exp %0d", got_r.timer_seq, exp_r.timer_seq));
      if (got_r.network_enable !== exp_r.network_enable) report("network_enable wrong");
      if (got_r.last !== exp_r.last) report("last wrong");
    endtask
  endclass

  arq_scoreboard board = new();
  int unsigned quiet_cycles = 0;

  initial begin
    ev_if.valid = 1'b0;
    ev_if.op = '0;
    ev_if.packet_word = '0;
    ev_if.frame_good = 1'b0;
    ev_if.frame_kind = '0;
    ev_if.frame_seq = '0;
    ev_if.rx_ack = '0;
    ev_if.timeout_seq = '0;
    act_if.ready = 1'b0;
  end

  // Result side: random stalls while out_idle_on is set, checked at each accepting edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (act_if.valid && act_if.ready) begin
        board.check_result('{act_if.action, act_if.out_kind, act_if.out_seq, act_if.out_ack,
                             act_if.payload, act_if.timer_seq, act_if.network_enable,
                             act_if.last});
      end
      act_if.ready <= out_idle_on ? ($urandom_range(0, 99) >= 33) : 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if ((ev_if.valid && ev_if.ready) || (act_if.valid && act_if.ready) || !rst_ni)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > IdleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Valid stays high from one transaction to the next unless an idle cycle
  // is drawn; the caller drops it after the last transaction.
  task automatic send_event(arq_event_t e, bit idles);
    while (idles && $urandom_range(0, 99) < 33) begin
      ev_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    ev_if.valid <= 1'b1;
    ev_if.op <= e.op;
    ev_if.packet_word <= e.packet_word;
    ev_if.frame_good <= e.frame_good;
    ev_if.frame_kind <= e.frame_kind;
    ev_if.frame_seq <= e.frame_seq;
    ev_if.rx_ack <= e.rx_ack;
    ev_if.timeout_seq <= e.timeout_seq;
    do @(posedge clk_i); while (!ev_if.ready);
    board.note_event(e);
  endtask

  function automatic arq_event_t make_event(logic [2:0] op, logic [63:0] w, bit good,
                                            logic [1:0] kind, logic [4:0] sq, logic [4:0] ak,
                                            logic [4:0] ts);
    arq_event_t e;
    e = '{op, w, good, kind, sq, ak, ts};
    return e;
  endfunction

  function automatic logic [63:0] rand_word();
    return {$urandom(), $urandom()};
  endfunction

  // Mostly a well-behaved peer: packets, acks to real frames, in-window data.
  function automatic arq_event_t random_event();
    int unsigned pick;
    logic [4:0] span;
    pick = $urandom_range(0, 99);
    span = board.snd_out;
    if (pick < 25)
      return make_event(OpPacket, rand_word(), 0, 0, 0, 0, 0);
    if (pick < 33)
      return make_event(OpPhysReady, 0, 0, 0, 0, 0, 0);
    if (pick < 45)
      return make_event(OpFrame, 0, 1, KindAck, 5'($urandom()),
                        5'(board.snd_lo + $urandom_range(0, span + 1) - 1), 0);
    if (pick < 52)
      return make_event(OpFrame, 0, 1, KindNak, 5'($urandom()),
                        5'(board.snd_lo + $urandom_range(0, span + 1) - 1), 0);
    if (pick < 75)
      return make_event(OpFrame, rand_word(), 1, KindData,
                        5'(board.rcv_lo + $urandom_range(0, pick < 60 ? 3 : 17)),
                        5'(board.snd_lo + $urandom_range(0, span) - 1), 0);
    if (pick < 80)
      return make_event(OpFrame, rand_word(), 0, 2'($urandom()), 5'($urandom()),
                        5'($urandom()), 0);
    if (pick < 87 && span != 0)
      return make_event(OpDataTimeout, 0, 0, 0, 0, 0,
                        5'(board.snd_lo + $urandom_range(0, span - 1)));
    if (pick < 93)
      return make_event(OpAckTimeout, 0, 0, 0, 0, 0, 0);
    // Noise: unknown ops, unknown kinds and random fields.
    return make_event($urandom_range(0, 1) ? 3'($urandom_range(5, 7)) : OpFrame, rand_word(),
                      1, 2'd3, 5'($urandom()), 5'($urandom()), 5'($urandom()));
  endfunction

  initial begin
    board.clear();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: field extremes, every op, unknown ops and kinds, full window.
    send_event(make_event(OpPhysReady, 0, 0, 0, 0, 0, 0), 0);
    send_event(make_event(OpPacket, '1, 0, 0, 0, 0, 0), 0);
    send_event(make_event(OpPacket, '0, 0, 0, 0, 0, 0), 0);
    send_event(make_event(OpDataTimeout, 0, 0, 0, 0, 0, 5'd1), 0);
    send_event(make_event(OpAckTimeout, 0, 0, 0, 0, 0, 0), 0);
    send_event(make_event(OpFrame, 0, 0, KindData, 0, 0, 0), 0);
    send_event(make_event(OpFrame, 0, 0, KindData, 0, 0, 0), 0);
    send_event(make_event(OpFrame, '1, 1, KindData, 5'd2, 5'd31, 5'd31), 0);
    send_event(make_event(OpFrame, 64'h1, 1, KindData, 5'd0, 5'd31, 0), 0);
    send_event(make_event(OpFrame, 64'h8000_0000_0000_0000, 1, KindData, 5'd1, 5'd31, 0), 0);
    send_event(make_event(OpFrame, 0, 1, KindData, 5'd31, 5'd31, 0), 0);
    send_event(make_event(OpFrame, 0, 1, KindNak, 0, 5'd31, 0), 0);
    send_event(make_event(OpFrame, 0, 1, KindAck, 0, 5'd1, 0), 0);
    send_event(make_event(OpFrame, '1, 1, 2'd3, 5'd31, 5'd31, 5'd31), 0);
    send_event(make_event(3'd5, 0, 0, 0, 0, 0, 0), 0);
    send_event(make_event(3'd7, '1, 1, 2'd3, 5'd31, 5'd31, 5'd31), 0);
    for (int i = 0; i < 17; i++)
      send_event(make_event(OpPacket, rand_word(), 0, 0, 0, 0, 0), 0);
    send_event(make_event(OpPhysReady, 0, 0, 0, 0, 0, 0), 0);
    send_event(make_event(OpFrame, 0, 1, KindAck, 0, 5'd17, 0), 0);

    // Random part, the first stretch without any idling.
    for (int i = 0; i < 65; i++) begin
      out_idle_on = !(i < 30);
      send_event(random_event(), i >= 30);
    end
    ev_if.valid <= 1'b0;
    out_idle_on = 1'b1;

    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (errors == 0 && board.pending.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
